[src/slu8_pkg.sv]
package slu8_pkg;

  localparam int unsigned CfgWidth = 13;
  localparam int unsigned LenWidth = 13;

  typedef enum logic [1:0] {
    VerdictPending = 2'd0,
    VerdictValid   = 2'd1,
    VerdictReject  = 2'd2
  } verdict_e;

  typedef enum logic {
    CfgMaxBytes      = 1'b0,
    CfgMaxCodePoints = 1'b1
  } cfg_index_e;

  localparam logic [CfgWidth-1:0] MaxBytesReset      = 13'd4096;
  localparam logic [CfgWidth-1:0] MaxCodePointsReset = 13'd1024;

  localparam logic [7:0] ByteNul = 8'h00;
  localparam logic [7:0] ByteLf  = 8'h0a;
  localparam logic [7:0] ByteCr  = 8'h0d;

  localparam logic [7:0] Lead2Min = 8'hc2;
  localparam logic [7:0] Lead2Max = 8'hdf;
  localparam logic [7:0] Lead3Min = 8'he0;
  localparam logic [7:0] Lead3Max = 8'hef;
  localparam logic [7:0] Lead4Min = 8'hf0;
  localparam logic [7:0] Lead4Max = 8'hf4;

  localparam logic [20:0] CodeMax      = 21'h10ffff;
  localparam logic [20:0] SurrogateLo  = 21'h00d800;
  localparam logic [20:0] SurrogateHi  = 21'h00dfff;
  localparam logic [20:0] Min2Byte     = 21'h000080;
  localparam logic [20:0] Min3Byte     = 21'h000800;
  localparam logic [20:0] Min4Byte     = 21'h010000;

  typedef struct packed {
    verdict_e            verdict;
    logic [7:0]          data;
    logic [LenWidth-1:0] length;
    logic                last;
  } result_t;

endpackage

[src/secret_line_utf8_checker.sv]
// Line checker for terminal input: bytes enter one per transfer on the input
// channel (in_valid_i / in_ready_o / data_byte_i) and each byte yields exactly
// one result on the output channel (out_valid_o / out_ready_i).
// A result with line_end_o low forwards the byte (verdict 0) for storage.
// CR or LF ends the line with verdict 1 (valid) or 2 (rejected); NUL or a byte
// past the byte limit ends it at once with verdict 2. line_length_o gives the
// stored byte count. A new line starts after every verdict.
// Limits are set through the write channel (cfg_valid_i / cfg_ready_o):
// index 0 is max_bytes, index 1 is max_code_points. Write only while idle.
// A byte passes the input register, then the result register, before its
// result shows on out_valid_o. Throughput: one byte per cycle while the
// receiver takes each result; the line state updates in a single pass
// between the two registers.
// When the receiver stalls, the result is held and the input register keeps
// one more byte, after which in_ready_o drops until the result is taken.
// Reset clears the line state and the valid bits of both registers and loads
// max_bytes 4096 and max_code_points 1024.
module secret_line_utf8_checker #(
  parameter int unsigned LINE_LIMIT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic [7:0]  byte_out_o,
  output logic [12:0] line_length_o,
  output logic        line_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  logic [slu8_pkg::CfgWidth-1:0] max_bytes_q, max_cp_q;
  logic                          stage_valid, core_ready;
  logic [7:0]                    stage_data;
  slu8_pkg::result_t             result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= slu8_pkg::MaxBytesReset;
      max_cp_q    <= slu8_pkg::MaxCodePointsReset;
    end else if (cfg_valid_i) begin
      unique case (slu8_pkg::cfg_index_e'(cfg_index_i))
        slu8_pkg::CfgMaxBytes:      max_bytes_q <= cfg_data_i;
        slu8_pkg::CfgMaxCodePoints: max_cp_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  slu8_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .valid_o     (stage_valid),
    .take_i      (core_ready),
    .data_o      (stage_data)
  );

  slu8_line_core #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_line_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (stage_valid),
    .ready_o           (core_ready),
    .data_i            (stage_data),
    .max_bytes_i       (max_bytes_q),
    .max_code_points_i (max_cp_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_o          (result)
  );

  assign verdict_o     = result.verdict;
  assign byte_out_o    = result.data;
  assign line_length_o = result.length;
  assign line_end_o    = result.last;

endmodule

[src/slu8_in_stage.sv]
module slu8_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       valid_o,
  input  logic       take_i,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;

  // Refill in the same cycle the held byte moves on.
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_valid_i ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/slu8_line_core.sv]
module slu8_line_core #(
  parameter int unsigned LINE_LIMIT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [7:0]                    data_i,
  input  logic [slu8_pkg::CfgWidth-1:0] max_bytes_i,
  input  logic [slu8_pkg::CfgWidth-1:0] max_code_points_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output slu8_pkg::result_t             result_o
);

  localparam int unsigned CntW = $clog2(LINE_LIMIT + 1);
  localparam int unsigned CmpW = (CntW > slu8_pkg::CfgWidth) ? CntW : slu8_pkg::CfgWidth;
  localparam logic [CmpW-1:0] LimitExt = CmpW'(LINE_LIMIT);

  logic [CntW-1:0] bytes_q, bytes_d;
  logic [1:0]      cont_q, cont_d;
  logic [1:0]      width_q, width_d;
  logic [20:0]     partial_q, partial_d;
  logic [CntW-1:0] count_q, count_d;
  logic            failed_q, failed_d;
  logic            out_valid_q;
  slu8_pkg::result_t result_q, result_d;

  logic            fire;
  logic [CmpW-1:0] bytes_ext, bytes_inc_ext, max_bytes_ext, limit, max_cp_ext, count_inc_ext;
  logic [CntW-1:0] bytes_inc, count_inc;
  logic            is_end, is_reject;
  logic [1:0]      cont_dec;
  logic [20:0]     pv_cont, fin_v;
  logic [1:0]      fin_w;
  logic            fin_form_bad, fin_over;

  assign ready_o = !out_valid_q || out_ready_i;
  assign fire    = valid_i && ready_o;

  assign bytes_ext     = CmpW'(bytes_q);
  assign bytes_inc     = bytes_q + 1'b1;
  assign bytes_inc_ext = CmpW'(bytes_inc);
  assign max_bytes_ext = CmpW'(max_bytes_i);
  assign limit         = (max_bytes_ext < LimitExt) ? max_bytes_ext : LimitExt;
  assign max_cp_ext    = CmpW'(max_code_points_i);

  assign is_end    = (data_i == slu8_pkg::ByteCr) || (data_i == slu8_pkg::ByteLf);
  assign is_reject = (data_i == slu8_pkg::ByteNul) || (bytes_ext >= limit);

  // Candidate code point: either the continuation completes one, or an ASCII byte.
  assign cont_dec = cont_q - 2'd1;
  assign pv_cont  = {partial_q[14:0], data_i[5:0]};
  assign fin_v    = (cont_q != 2'd0) ? pv_cont : {13'd0, data_i};
  assign fin_w    = (cont_q != 2'd0) ? width_q : 2'd0;

  assign fin_form_bad = (fin_w == 2'd1 && fin_v < slu8_pkg::Min2Byte) ||
                        (fin_w == 2'd2 && fin_v < slu8_pkg::Min3Byte) ||
                        (fin_w == 2'd3 && fin_v < slu8_pkg::Min4Byte) ||
                        (fin_v > slu8_pkg::CodeMax) ||
                        (fin_v >= slu8_pkg::SurrogateLo && fin_v <= slu8_pkg::SurrogateHi) ||
                        (fin_v == 21'd0) || (fin_v == 21'd10) || (fin_v == 21'd13);
  assign count_inc     = count_q + 1'b1;
  assign count_inc_ext = CmpW'(count_inc);
  assign fin_over      = count_inc_ext > max_cp_ext;

  always_comb begin
    bytes_d   = bytes_q;
    cont_d    = cont_q;
    width_d   = width_q;
    partial_d = partial_q;
    count_d   = count_q;
    failed_d  = failed_q;
    result_d.verdict = slu8_pkg::VerdictPending;
    result_d.data    = 8'd0;
    result_d.length  = bytes_ext[slu8_pkg::LenWidth-1:0];
    result_d.last    = 1'b1;

    if (is_end || is_reject) begin
      result_d.verdict = (is_end && !failed_q && cont_q == 2'd0) ?
                         slu8_pkg::VerdictValid : slu8_pkg::VerdictReject;
      bytes_d   = '0;
      cont_d    = 2'd0;
      width_d   = 2'd0;
      partial_d = 21'd0;
      count_d   = '0;
      failed_d  = 1'b0;
    end else begin
      bytes_d         = bytes_inc;
      result_d.data   = data_i;
      result_d.length = bytes_inc_ext[slu8_pkg::LenWidth-1:0];
      result_d.last   = 1'b0;
      if (!failed_q) begin
        if (cont_q != 2'd0 && data_i[7:6] != 2'b10) begin
          failed_d = 1'b1;
        end else if (cont_q != 2'd0 && cont_dec != 2'd0) begin
          partial_d = pv_cont;
          cont_d    = cont_dec;
        end else if (cont_q != 2'd0 || data_i < 8'h80) begin
          // Complete one code point.
          cont_d    = 2'd0;
          width_d   = 2'd0;
          partial_d = 21'd0;
          if (fin_form_bad) begin
            failed_d = 1'b1;
          end else begin
            count_d = count_inc;
            if (fin_over) begin
              failed_d = 1'b1;
            end
          end
        end else if (data_i >= slu8_pkg::Lead2Min && data_i <= slu8_pkg::Lead2Max) begin
          partial_d = {16'd0, data_i[4:0]};
          width_d   = 2'd1;
          cont_d    = 2'd1;
        end else if (data_i >= slu8_pkg::Lead3Min && data_i <= slu8_pkg::Lead3Max) begin
          partial_d = {17'd0, data_i[3:0]};
          width_d   = 2'd2;
          cont_d    = 2'd2;
        end else if (data_i >= slu8_pkg::Lead4Min && data_i <= slu8_pkg::Lead4Max) begin
          partial_d = {18'd0, data_i[2:0]};
          width_d   = 2'd3;
          cont_d    = 2'd3;
        end else begin
          failed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q     <= '0;
      cont_q      <= 2'd0;
      width_q     <= 2'd0;
      partial_q   <= 21'd0;
      count_q     <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        bytes_q     <= bytes_d;
        cont_q      <= cont_d;
        width_q     <= width_d;
        partial_q   <= partial_d;
        count_q     <= count_d;
        failed_q    <= failed_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

[src/slu8_checker.sv]
module slu8_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  verdict_o,
  input logic [7:0]  byte_out_o,
  input logic [12:0] line_length_o,
  input logic        line_end_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o) &&
    $stable(byte_out_o) && $stable(line_length_o) && $stable(line_end_o))
    else $error("stalled result changed");

  // Verdict and line end agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_end_o == (verdict_o != slu8_pkg::VerdictPending)) &&
    (verdict_o != 2'd3))
    else $error("verdict and line end disagree");

  // A forwarded byte is never an ending or NUL byte and counts at least one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_end_o |-> byte_out_o != slu8_pkg::ByteNul &&
    byte_out_o != slu8_pkg::ByteCr && byte_out_o != slu8_pkg::ByteLf &&
    line_length_o != 13'd0)
    else $error("bad forwarded byte");

  // Consecutive forwarded bytes of a line count up by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !line_end_o ##1 out_valid_o && !line_end_o
    |-> line_length_o == $past(line_length_o) + 13'd1)
    else $error("line length did not advance");

  // With no result waiting, the input always has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with no result waiting");

endmodule

bind secret_line_utf8_checker slu8_checker u_slu8_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .verdict_o     (verdict_o),
  .byte_out_o    (byte_out_o),
  .line_length_o (line_length_o),
  .line_end_o    (line_end_o)
);
